// ----- rtl/sssp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg
// shared types and constants for the shortest path block
// ----------------------------------------------------------------------------
package sssp_pkg;

	localparam int NODE_W = 11;
	localparam int WGT_W  = 31;
	localparam int DIST_W = 42;
	localparam int LEN_W  = 41;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_edge;
		logic init_start;
		logic scan_start;
		logic scan_step;
		logic relax_start;
		logic relax_step;
		logic visit;
		logic read_dest;
		logic run_done;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_done;
		logic scan_done;
		logic found;
		logic relax_done;
	} dp_stat_t;

endpackage

// ----- rtl/sssp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/sssp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_datapath
// edge store, distance store, minimum scan and edge relaxation
// ----------------------------------------------------------------------------
module sssp_datapath #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sssp_pkg::ctrl_cmd_t       cmd,
	input  logic [10:0]               node_count,
	input  logic [10:0]               from_node,
	input  logic [10:0]               to_node,
	input  logic [30:0]               edge_weight,
	output sssp_pkg::dp_stat_t        stat,
	output logic                      status,
	output logic [40:0]               path_length,
	output logic                      edges_dropped
);
	import sssp_pkg::*;

	localparam int NA = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NC = $clog2(MAX_NODES + 1);
	localparam int EC = $clog2(MAX_EDGES + 1);
	localparam int CW = (NC > NODE_W) ? NC : NODE_W;
	localparam int EW = NA + NA + WGT_W;
	localparam int DW = DIST_W + 1;

	// effective node count
	logic [CW-1:0] nc_ext;
	logic [NC-1:0] cnt;
	always_comb begin
		nc_ext = CW'(node_count);
		if (nc_ext == '0) begin
			cnt = NC'(1);
		end else if (nc_ext > CW'(MAX_NODES)) begin
			cnt = NC'(MAX_NODES);
		end else begin
			cnt = NC'(nc_ext);
		end
	end

	// edge add checks
	logic [EC-1:0] edge_total_q;
	logic          drop_q;
	logic [CW-1:0] f_ext, t_ext;
	logic          add_ok;
	assign f_ext = CW'(from_node);
	assign t_ext = CW'(to_node);
	assign add_ok = (edge_total_q < EC'(MAX_EDGES)) && (f_ext != '0) && (t_ext != '0)
		&& (f_ext <= CW'(cnt)) && (t_ext <= CW'(cnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			drop_q       <= 1'b0;
		end else if (cmd.run_done) begin
			edge_total_q <= '0;
			drop_q       <= 1'b0;
		end else if (cmd.load_edge) begin
			if (add_ok) begin
				edge_total_q <= edge_total_q + EC'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// sweep state
	logic [NC-1:0]     n_idx_q;
	logic [NC-1:0]     scan_rd_q;
	logic              scan_vld_q;
	logic [NA-1:0]     best_q;
	logic [DIST_W-1:0] best_d_q;
	logic              found_q;
	logic              init_q;
	logic              e_vld_q;
	logic [1:0]        rx_ph_q;
	logic [NA-1:0]     rx_t_q;
	logic [DIST_W-1:0] rx_nd_q;
	logic [EC-1:0]     e_sent_q;
	logic              rx_done;

	// edge store, read address follows the next edge to issue
	logic [EW-1:0] e_rdata;
	logic [EW-1:0] e_wdata;
	logic [EA-1:0] e_waddr;
	logic [EA-1:0] e_raddr;
	assign e_waddr = edge_total_q[EA-1:0];
	assign e_raddr = e_sent_q[EA-1:0];
	assign e_wdata = {NA'(f_ext - CW'(1)), NA'(t_ext - CW'(1)), edge_weight};
	sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(cmd.load_edge && add_ok), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	// node store: bit 42 visited, bit 41 infinite, low bits distance
	logic          n_we;
	logic [NA-1:0] n_waddr, n_raddr;
	logic [DW-1:0] n_wdata, n_rdata;
	sssp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_nodes (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	logic [NA-1:0] es, et;
	logic [WGT_W-1:0] ew;
	assign es = e_rdata[EW-1 -: NA];
	assign et = e_rdata[WGT_W +: NA];
	assign ew = e_rdata[WGT_W-1:0];

	// node store port control
	always_comb begin
		n_we    = 1'b0;
		n_waddr = n_idx_q[NA-1:0];
		n_wdata = '0;
		n_raddr = scan_rd_q[NA-1:0];
		if (init_q) begin
			n_we    = 1'b1;
			n_wdata = (n_idx_q == '0) ? DW'(0) : {1'b0, 1'b1, {(DIST_W-1){1'b0}}};
		end else if (cmd.visit) begin
			n_we    = 1'b1;
			n_waddr = best_q;
			n_wdata = {1'b1, best_d_q};
		end else if (rx_ph_q == 2'd2) begin
			n_raddr = rx_t_q;
			if (!n_rdata[DIST_W] && rx_nd_q < n_rdata[DIST_W-1:0]) begin
				n_we    = 1'b1;
				n_waddr = rx_t_q;
				n_wdata = {1'b0, rx_nd_q};
			end
		end else if (rx_ph_q == 2'd1) begin
			n_raddr = rx_t_q;
		end else if (cmd.read_dest) begin
			n_raddr = NA'(cnt - NC'(1));
		end
	end

	assign rx_done = (e_sent_q >= edge_total_q) && !e_vld_q && (rx_ph_q == 2'd0);

	// sequencing of init, scan and relax sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b0;
			n_idx_q    <= '0;
			scan_rd_q  <= '0;
			scan_vld_q <= 1'b0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_d_q   <= '0;
			e_vld_q    <= 1'b0;
			rx_ph_q    <= 2'd0;
			rx_t_q     <= '0;
			rx_nd_q    <= '0;
			e_sent_q   <= '0;
		end else begin
			// init sweep
			if (cmd.init_start) begin
				init_q  <= 1'b1;
				n_idx_q <= '0;
			end else if (init_q) begin
				if (n_idx_q == cnt - NC'(1)) begin
					init_q <= 1'b0;
				end
				n_idx_q <= n_idx_q + NC'(1);
			end
			// minimum scan, one node per cycle
			if (cmd.scan_start) begin
				scan_rd_q  <= '0;
				scan_vld_q <= 1'b0;
				found_q    <= 1'b0;
				best_d_q   <= {1'b1, {(DIST_W-1){1'b0}}};
			end else if (cmd.scan_step) begin
				if (scan_rd_q < cnt) begin
					scan_rd_q <= scan_rd_q + NC'(1);
				end
				scan_vld_q <= (scan_rd_q < cnt);
				if (scan_vld_q && !n_rdata[DIST_W] && n_rdata[DIST_W-1:0] < best_d_q) begin
					best_d_q <= n_rdata[DIST_W-1:0];
					best_q   <= NA'(scan_rd_q - NC'(1));
					found_q  <= 1'b1;
				end
			end
			// relaxation: read edge, read target, compare and write
			if (cmd.relax_start) begin
				e_sent_q <= '0;
				e_vld_q  <= 1'b0;
				rx_ph_q  <= 2'd0;
			end else if (cmd.relax_step) begin
				unique case (rx_ph_q)
					2'd0: begin
						if (e_vld_q) begin
							e_vld_q <= 1'b0;
							if (es == best_q && NC'(et) < cnt) begin
								rx_t_q  <= et;
								rx_nd_q <= best_d_q + DIST_W'(ew);
								rx_ph_q <= 2'd1;
							end
						end else if (e_sent_q < edge_total_q) begin
							e_sent_q <= e_sent_q + EC'(1);
							e_vld_q  <= 1'b1;
						end
					end
					2'd1: rx_ph_q <= 2'd2;
					2'd2: rx_ph_q <= 2'd0;
					default: rx_ph_q <= 2'd0;
				endcase
			end else if (cmd.run_done) begin
				rx_ph_q <= 2'd0;
			end
		end
	end

	// result fields, read at the end of the run
	assign status        = n_rdata[DIST_W-1];
	assign path_length   = n_rdata[DIST_W-1] ? '0 : n_rdata[LEN_W-1:0];
	assign edges_dropped = drop_q;

	assign stat.init_done  = !init_q;
	assign stat.scan_done  = (scan_rd_q >= cnt) && !scan_vld_q;
	assign stat.found      = found_q;
	assign stat.relax_done = rx_done;

endmodule

// ----- rtl/sssp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_ctrl
// controller for edge loading, search sweeps and result handoff
// ----------------------------------------------------------------------------
module sssp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_cmd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sssp_pkg::ctrl_cmd_t cmd,
	input  sssp_pkg::dp_stat_t  stat,
	output logic                capture
);
	import sssp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_VISIT = 3'd3;
	localparam logic [2:0] ST_RELAX = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_CAP   = 3'd6;

	logic [2:0] state_q;
	logic       start_q;
	logic       out_q;

	// edges stream in while idle and the output slot may still be full
	assign s_tready = (state_q == ST_IDLE) && !(s_cmd == CMD_RUN && out_q);
	assign m_tvalid = out_q;
	assign capture  = (state_q == ST_CAP);

	always_comb begin
		cmd = '0;
		cmd.load_edge   = s_tvalid && s_tready && (s_cmd == CMD_ADD);
		cmd.init_start  = (state_q == ST_INIT) && start_q;
		cmd.scan_start  = (state_q == ST_SCAN) && start_q;
		cmd.scan_step   = (state_q == ST_SCAN) && !start_q;
		cmd.visit       = (state_q == ST_VISIT);
		cmd.relax_start = (state_q == ST_RELAX) && start_q;
		cmd.relax_step  = (state_q == ST_RELAX) && !start_q;
		cmd.read_dest   = (state_q == ST_RD);
		cmd.run_done    = (state_q == ST_CAP);
	end

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_q <= 1'b0;
			end
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready && s_cmd == CMD_RUN) begin
						state_q <= ST_INIT;
						start_q <= 1'b1;
					end
				end
				ST_INIT: begin
					if (!start_q && stat.init_done) begin
						state_q <= ST_SCAN;
						start_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (!start_q && stat.scan_done) begin
						if (stat.found) begin
							state_q <= ST_VISIT;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_VISIT: begin
					state_q <= ST_RELAX;
					start_q <= 1'b1;
				end
				ST_RELAX: begin
					if (!start_q && stat.relax_done) begin
						state_q <= ST_SCAN;
						start_q <= 1'b1;
					end
				end
				ST_RD: state_q <= ST_CAP;
				ST_CAP: begin
					state_q <= ST_IDLE;
					out_q   <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/single_source_shortest_path.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path
// edge loader and shortest path search from node 1 to node node_count
// ----------------------------------------------------------------------------
// edge beats: one per cycle while idle, no result
// run beat: an init sweep, then per settled node a minimum scan, one visit
//   and one pass over all stored edges (the target of an edge that leaves the
//   settled node is read and updated if shorter), then a last scan and readout
// a run beat waits while the previous result is still held in the output slot
// reset clears edge count, drop flag, node count (to 1) and the output slot
module single_source_shortest_path #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // from_node, to_node, edge_weight
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // path_length, edges_dropped
	output logic        m_tuser   // status
);
	import sssp_pkg::*;

	logic [10:0] node_count_q;
	ctrl_cmd_t   cmd;
	dp_stat_t    stat;
	logic        capture;
	logic        status, dropped;
	logic [40:0] path_length;
	logic        res_status_q, res_drop_q;
	logic [40:0] res_len_q;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 11'd1;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	sssp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_cmd(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cmd(cmd), .stat(stat), .capture(capture)
	);

	sssp_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .node_count(node_count_q),
		.from_node(s_tdata[10:0]), .to_node(s_tdata[21:11]),
		.edge_weight(s_tdata[52:22]), .stat(stat), .status(status),
		.path_length(path_length), .edges_dropped(dropped)
	);

	// output register
	always_ff @(posedge clk) begin
		if (capture) begin
			res_status_q <= status;
			res_len_q    <= path_length;
			res_drop_q   <= dropped;
		end
	end

	assign m_tdata = {6'd0, res_drop_q, res_len_q};
	assign m_tuser = res_status_q;

endmodule
